// ===== design/pcse_pkg.sv =====
// Shared types, constants and helpers for the piecewise cubic spline evaluator.
// Used by every module of the block; depends on nothing.
package pcse_pkg;

	localparam int MAX_SEGMENTS_DEF = 16;
	localparam int FRAC_BITS_DEF    = 16;
	localparam int V_FRAC           = 16;
	localparam int COEFS_PER_SEG    = 12;

	localparam int DATA_W    = 32;
	localparam int CNT_W     = 5;
	localparam int IDX_W     = 5;
	localparam int SEL_W     = 4;
	localparam int V_W       = 17;
	localparam int SEG_OUT_W = 4;

	localparam int OPA_W  = 33;
	localparam int OPB_W  = 34;
	localparam int PROD_W = 67;
	localparam int SUM_W  = 68;
	localparam int U_W    = 36;

	localparam logic [1:0] CMD_WR_BP   = 2'd0;
	localparam logic [1:0] CMD_WR_COEF = 2'd1;
	localparam logic [1:0] CMD_EVAL    = 2'd2;

	localparam logic [1:0] SLOT_A = 2'd0;
	localparam logic [1:0] SLOT_B = 2'd1;
	localparam logic [1:0] SLOT_C = 2'd2;
	localparam logic [1:0] SLOT_D = 2'd3;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam logic [2:0] STEP_POS_D  = 3'd0;
	localparam logic [2:0] STEP_TAN_D3 = 3'd1;
	localparam logic [2:0] STEP_POS_B  = 3'd2;
	localparam logic [2:0] STEP_TAN_B  = 3'd3;
	localparam logic [2:0] STEP_POS_A  = 3'd4;
	localparam logic [2:0] STEP_CURV   = 3'd5;

	localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [1:0]              cmd;
		logic [IDX_W-1:0]        seg_index;
		logic [SEL_W-1:0]        coef_select;
		logic signed [DATA_W-1:0] load_value;
		logic [V_W-1:0]          param_v;
	} in_word_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] pos_x;
		logic signed [DATA_W-1:0] pos_y;
		logic signed [DATA_W-1:0] pos_z;
		logic signed [DATA_W-1:0] tan_x;
		logic signed [DATA_W-1:0] tan_y;
		logic signed [DATA_W-1:0] tan_z;
		logic signed [DATA_W-1:0] curv_x;
		logic signed [DATA_W-1:0] curv_y;
		logic signed [DATA_W-1:0] curv_z;
		logic [SEG_OUT_W-1:0]     found_segment;
		logic                     map_error;
	} out_word_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_T0,
		S_TN,
		S_UMUL,
		S_UWAIT,
		S_SRCH,
		S_CRD,
		S_CCAP,
		S_EVAL,
		S_DRAIN,
		S_DONE
	} seq_state_t;

	typedef enum logic [1:0] {
		DST_POS,
		DST_TAN,
		DST_CURV
	} dst_t;

	typedef struct packed {
		logic eval_go;
		logic hit;
		logic last;
	} seq_stat_t;

	typedef struct packed {
		seq_state_t state;
		logic [1:0] p;
		logic [2:0] step;
		logic [1:0] axis;
		logic       busy;
		logic       done;
	} seq_ctrl_t;

	typedef struct packed {
		logic                    horner;
		logic signed [OPA_W-1:0] a;
		logic signed [OPB_W-1:0] b;
		logic signed [OPA_W-1:0] addend;
	} mac_op_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
		if (x > SUM_W'(S32_MAX)) begin
			return S32_MAX;
		end else if (x < SUM_W'(S32_MIN)) begin
			return S32_MIN;
		end else begin
			return $signed(x[DATA_W-1:0]);
		end
	endfunction

endpackage

// ===== design/piecewise_cubic_spline_evaluator_unit.sv =====
// Piecewise cubic spline evaluator: breakpoint and coefficient stores, search, Horner datapath.
// Load commands are written when accepted and leave busy low. An evaluate holds busy until done,
// which strobes in its last busy cycle; the search makes one read per breakpoint, and each axis
// takes six two-stage passes of the shared multiply-add. Results cannot be stalled.
// arst_n clears the sequencer and sets segment_count to 1; the stores are not cleared.
module piecewise_cubic_spline_evaluator_unit
	import pcse_pkg::*;
#(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  in_word_t         request,
	output logic             done,
	output out_word_t        result,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_data
);

	localparam int BP_DEPTH = MAX_SEGMENTS + 1;
	localparam int CF_DEPTH = MAX_SEGMENTS * COEFS_PER_SEG;
	localparam int BA_W     = $clog2(BP_DEPTH);
	localparam int CA_W     = $clog2(CF_DEPTH);
	localparam int D3_W     = DATA_W + 2;
	localparam int D6_W     = DATA_W + 3;

	seq_ctrl_t ctrl;
	seq_stat_t stat;

	logic [CNT_W-1:0] seg_count_q;
	logic [BA_W-1:0]  n_c;
	logic             accept;
	logic             eval_go;
	logic             bp_we;
	logic             cf_we;
	logic [BA_W-1:0]  bp_waddr;
	logic [BA_W-1:0]  bp_raddr;
	logic [CA_W-1:0]  cf_waddr;

	logic signed [DATA_W-1:0] bp_mem [BP_DEPTH];
	logic signed [DATA_W-1:0] cf_mem [CF_DEPTH];
	logic signed [DATA_W-1:0] bp_rd_q;
	logic signed [DATA_W-1:0] cf_rd_q;

	logic [BA_W-1:0]          n_q;
	logic [BA_W-1:0]          k_q;
	logic [BA_W-1:0]          j_q;
	logic [BA_W-1:0]          j_c;
	logic [CA_W-1:0]          base_c;
	logic [CA_W-1:0]          caddr_q;
	logic [V_W-1:0]           v_q;
	logic signed [DATA_W-1:0] t0_q;
	logic signed [DATA_W-1:0] prev_q;
	logic signed [OPA_W-1:0]  diff_q;
	logic signed [U_W-1:0]    u_q;
	logic signed [U_W-1:0]    u_off;
	logic [DATA_W-1:0]        s_q;
	logic                     err_q;
	logic                     hit;
	logic                     last;

	logic signed [DATA_W-1:0] a_q;
	logic signed [DATA_W-1:0] b_q;
	logic signed [DATA_W-1:0] c_q;
	logic signed [DATA_W-1:0] d_q;
	logic signed [DATA_W-1:0] d3_q;
	logic signed [DATA_W-1:0] d6_q;
	logic signed [D3_W-1:0]   d3_w;
	logic signed [D6_W-1:0]   d6_w;
	logic                     cap_vld_s1;
	logic [1:0]               cap_slot_s1;

	logic signed [DATA_W-1:0] pos_q  [3];
	logic signed [DATA_W-1:0] tan_q  [3];
	logic signed [DATA_W-1:0] curv_q [3];

	logic                     mac_issue;
	mac_op_t                  mac_op;
	logic signed [DATA_W-1:0] res_sat;
	logic signed [U_W-1:0]    res_wide;
	logic signed [DATA_W-1:0] acc_c;
	logic signed [OPA_W-1:0]  term_c;
	logic signed [OPA_W-1:0]  c2_c;
	dst_t                     dst_c;
	logic                     evl_vld_s1;
	dst_t                     dst_s1;
	logic [1:0]               axis_s1;

	pcse_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	pcse_mac #(
		.FRAC_BITS (FRAC_BITS)
	) u_mac (
		.clk      (clk),
		.issue    (mac_issue),
		.op       (mac_op),
		.res_sat  (res_sat),
		.res_wide (res_wide)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count_q <= CNT_W'(1);
		end else if (cfg_we) begin
			seg_count_q <= cfg_data;
		end
	end

	always_comb begin
		if (seg_count_q == '0) begin
			n_c = BA_W'(1);
		end else if (32'(seg_count_q) > 32'(MAX_SEGMENTS)) begin
			n_c = BA_W'(MAX_SEGMENTS);
		end else begin
			n_c = BA_W'(seg_count_q);
		end
	end

	assign busy     = ctrl.busy;
	assign done     = ctrl.done;
	assign accept   = start && !ctrl.busy;
	assign eval_go  = accept && (request.cmd == CMD_EVAL);
	assign bp_we    = accept && (request.cmd == CMD_WR_BP)
		&& (32'(request.seg_index) <= 32'(MAX_SEGMENTS));
	assign cf_we    = accept && (request.cmd == CMD_WR_COEF)
		&& (32'(request.seg_index) < 32'(MAX_SEGMENTS))
		&& (request.coef_select < SEL_W'(COEFS_PER_SEG));
	assign bp_waddr = BA_W'(request.seg_index);
	assign cf_waddr = CA_W'((32'(request.seg_index) << 3) + (32'(request.seg_index) << 2)
		+ 32'(request.coef_select));

	assign hit   = (u_q >= U_W'(prev_q)) && (u_q <= U_W'(bp_rd_q));
	assign last  = (k_q == n_q);
	assign u_off = u_q - U_W'(prev_q);
	assign j_c   = k_q - 1'b1;
	assign base_c = CA_W'({j_c, 3'b000}) + CA_W'({j_c, 2'b00});

	assign stat.eval_go = eval_go;
	assign stat.hit     = hit;
	assign stat.last    = last;

	always_comb begin
		case (ctrl.state)
			S_IDLE:  bp_raddr = '0;
			S_T0:    bp_raddr = n_q;
			S_SRCH:  bp_raddr = (hit || last) ? k_q : k_q + 1'b1;
			default: bp_raddr = k_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (bp_we) begin
			bp_mem[bp_waddr] <= request.load_value;
		end
		bp_rd_q <= bp_mem[bp_raddr];
	end

	always_ff @(posedge clk) begin
		if (cf_we) begin
			cf_mem[cf_waddr] <= request.load_value;
		end
		cf_rd_q <= cf_mem[caddr_q];
	end

	// search: map v to u, then walk breakpoint pairs until u falls inside one or the last pair is passed
	always_ff @(posedge clk) begin
		if (eval_go) begin
			v_q <= request.param_v;
			n_q <= n_c;
		end
		case (ctrl.state)
			S_T0: t0_q <= bp_rd_q;
			S_TN: begin
				diff_q <= OPA_W'(bp_rd_q) - OPA_W'(t0_q);
				k_q    <= BA_W'(1);
			end
			S_UWAIT: begin
				u_q    <= res_wide;
				prev_q <= t0_q;
			end
			S_SRCH: begin
				if (hit) begin
					s_q     <= u_off[DATA_W-1:0];
					j_q     <= j_c;
					caddr_q <= base_c;
					err_q   <= 1'b0;
				end else if (last) begin
					err_q <= 1'b1;
				end else begin
					prev_q <= bp_rd_q;
					k_q    <= k_q + 1'b1;
				end
			end
			S_CRD: caddr_q <= caddr_q + 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_vld_s1 <= 1'b0;
			evl_vld_s1 <= 1'b0;
		end else begin
			cap_vld_s1 <= (ctrl.state == S_CRD);
			evl_vld_s1 <= (ctrl.state == S_EVAL);
		end
	end

	always_ff @(posedge clk) begin
		cap_slot_s1 <= ctrl.p;
		dst_s1      <= dst_c;
		axis_s1     <= ctrl.axis;
	end

	assign d3_w = D3_W'(cf_rd_q) + (D3_W'(cf_rd_q) <<< 1);
	assign d6_w = D6_W'(d3_w) <<< 1;

	always_ff @(posedge clk) begin
		if (cap_vld_s1) begin
			case (cap_slot_s1)
				SLOT_A: a_q <= cf_rd_q;
				SLOT_B: b_q <= cf_rd_q;
				SLOT_C: c_q <= cf_rd_q;
				SLOT_D: begin
					d_q  <= cf_rd_q;
					d3_q <= sat32(SUM_W'(d3_w));
					d6_q <= sat32(SUM_W'(d6_w));
				end
				default: ;
			endcase
		end
	end

	assign c2_c = OPA_W'(c_q) <<< 1;

	always_comb begin
		case (ctrl.step)
			STEP_POS_D: begin
				acc_c  = d_q;
				term_c = OPA_W'(c_q);
				dst_c  = DST_POS;
			end
			STEP_TAN_D3: begin
				acc_c  = d3_q;
				term_c = c2_c;
				dst_c  = DST_TAN;
			end
			STEP_POS_B: begin
				acc_c  = pos_q[ctrl.axis];
				term_c = OPA_W'(b_q);
				dst_c  = DST_POS;
			end
			STEP_TAN_B: begin
				acc_c  = tan_q[ctrl.axis];
				term_c = OPA_W'(b_q);
				dst_c  = DST_TAN;
			end
			STEP_POS_A: begin
				acc_c  = pos_q[ctrl.axis];
				term_c = OPA_W'(a_q);
				dst_c  = DST_POS;
			end
			default: begin
				acc_c  = d6_q;
				term_c = c2_c;
				dst_c  = DST_CURV;
			end
		endcase

		if (ctrl.state == S_UMUL) begin
			mac_issue     = 1'b1;
			mac_op.horner = 1'b0;
			mac_op.a      = diff_q;
			mac_op.b      = $signed(OPB_W'(v_q));
			mac_op.addend = OPA_W'(t0_q);
		end else begin
			mac_issue     = (ctrl.state == S_EVAL);
			mac_op.horner = 1'b1;
			mac_op.a      = OPA_W'(acc_c);
			mac_op.b      = $signed({2'b00, s_q});
			mac_op.addend = term_c;
		end
	end

	always_ff @(posedge clk) begin
		if (evl_vld_s1) begin
			unique case (dst_s1)
				DST_POS:  pos_q[axis_s1]  <= res_sat;
				DST_TAN:  tan_q[axis_s1]  <= res_sat;
				DST_CURV: curv_q[axis_s1] <= res_sat;
				default: ;
			endcase
		end
	end

	always_comb begin
		result.pos_x         = err_q ? '0 : pos_q[AXIS_X];
		result.pos_y         = err_q ? '0 : pos_q[AXIS_Y];
		result.pos_z         = err_q ? '0 : pos_q[AXIS_Z];
		result.tan_x         = err_q ? '0 : tan_q[AXIS_X];
		result.tan_y         = err_q ? '0 : tan_q[AXIS_Y];
		result.tan_z         = err_q ? '0 : tan_q[AXIS_Z];
		result.curv_x        = err_q ? '0 : curv_q[AXIS_X];
		result.curv_y        = err_q ? '0 : curv_q[AXIS_Y];
		result.curv_z        = err_q ? '0 : curv_q[AXIS_Z];
		result.found_segment = err_q ? '0 : SEG_OUT_W'(j_q);
		result.map_error     = err_q;
	end

endmodule

// ===== design/pcse_mac.sv =====
// Shared multiply, floor-shift, add and saturate unit of the spline evaluator.
// Product registered, then shift/add/saturate combinational. Depends on pcse_pkg.
module pcse_mac
	import pcse_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     issue,
	input  mac_op_t                  op,
	output logic signed [DATA_W-1:0] res_sat,
	output logic signed [U_W-1:0]    res_wide
);

	logic signed [PROD_W-1:0] prod_c;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [OPA_W-1:0]  addend_s1;
	logic                     horner_s1;
	logic signed [PROD_W-1:0] shifted;
	logic signed [SUM_W-1:0]  sum;

	assign prod_c = $signed(op.a) * $signed(op.b);

	always_ff @(posedge clk) begin
		if (issue) begin
			prod_s1   <= prod_c;
			addend_s1 <= op.addend;
			horner_s1 <= op.horner;
		end
	end

	always_comb begin
		shifted  = horner_s1 ? (prod_s1 >>> FRAC_BITS) : (prod_s1 >>> V_FRAC);
		sum      = SUM_W'(shifted) + SUM_W'(addend_s1);
		res_sat  = sat32(sum);
		res_wide = $signed(sum[U_W-1:0]);
	end

endmodule

// ===== design/pcse_seq.sv =====
// Sequencer of the spline evaluator: state register, load/step/axis counters.
// Depends on pcse_pkg.
module pcse_seq
	import pcse_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  seq_stat_t stat,
	output seq_ctrl_t ctrl
);

	seq_state_t state_q;
	seq_state_t state_d;
	logic [1:0] p_q;
	logic [2:0] step_q;
	logic [1:0] axis_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (stat.eval_go) begin
					state_d = S_T0;
				end
			end
			S_T0:    state_d = S_TN;
			S_TN:    state_d = S_UMUL;
			S_UMUL:  state_d = S_UWAIT;
			S_UWAIT: state_d = S_SRCH;
			S_SRCH: begin
				if (stat.hit) begin
					state_d = S_CRD;
				end else if (stat.last) begin
					state_d = S_DONE;
				end
			end
			S_CRD: begin
				if (p_q == SLOT_D) begin
					state_d = S_CCAP;
				end
			end
			S_CCAP: state_d = S_EVAL;
			S_EVAL: begin
				if (step_q == STEP_CURV) begin
					state_d = (axis_q == AXIS_Z) ? S_DRAIN : S_CRD;
				end
			end
			S_DRAIN: state_d = S_DONE;
			S_DONE:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase

		ctrl.state = state_q;
		ctrl.p     = p_q;
		ctrl.step  = step_q;
		ctrl.axis  = axis_q;
		ctrl.busy  = (state_q != S_IDLE);
		ctrl.done  = (state_q == S_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q    <= '0;
			step_q <= '0;
			axis_q <= '0;
		end else begin
			case (state_q)
				S_UWAIT: begin
					p_q    <= '0;
					step_q <= '0;
					axis_q <= AXIS_X;
				end
				S_CRD: p_q <= p_q + 2'd1;
				S_EVAL: begin
					if (step_q == STEP_CURV) begin
						step_q <= '0;
						axis_q <= axis_q + 2'd1;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				default: ;
			endcase
		end
	end

endmodule
